// ===== hw/rtl/crp_pkg.sv =====
// Package for the cipher rotor permutation block.
// Holds request kinds, request and response payload types and default sizes.
// No dependencies.
package crp_pkg;

    localparam int unsigned SYMBOLS_DEF = 256;
    localparam int unsigned FIELD_W     = 8;

    typedef enum logic [2:0] {
        KIND_LOAD     = 3'd0,
        KIND_FORWARD  = 3'd1,
        KIND_BACKWARD = 3'd2,
        KIND_ROTATE   = 3'd3,
        KIND_RESET    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] symbol;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               wrapped;
    } t_rsp;

endpackage

// ===== hw/rtl/cipher_rotor_permutation.sv =====
// Cipher rotor permutation: base and inverse tables in synchronous memories,
// rotation count and wrap flag in registers. Depends on crp_pkg.
//
// One request per cycle when not stalled. An accepted request first issues
// the table read (or writes the tables for a load, and updates the count
// for a rotate or reset); its response is then registered in the output stage.
// A load writes at its own accept edge, so a read accepted on the next edge
// already sees the new entry. Both tables come out of reset undefined; only
// entries that have been loaded may be looked up. One response per request.
module cipher_rotor_permutation
    import crp_pkg::*;
#(
    parameter int unsigned SYMBOLS = SYMBOLS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int unsigned IDX_W = $clog2(SYMBOLS);
    localparam int unsigned CW    = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;

    logic [FIELD_W-1:0] base_mem [SYMBOLS];
    logic [IDX_W-1:0]   inv_mem  [SYMBOLS];

    logic [IDX_W-1:0]   r_rot;
    logic [IDX_W-1:0]   n_rot;
    logic               r_wrap;
    logic               n_wrap;

    logic               r_s1_vld;
    t_kind              r_s1_kind;
    logic               r_s1_ok;
    logic [IDX_W-1:0]   r_s1_rot;
    logic               r_s1_wrap;
    logic [FIELD_W-1:0] r_base_rd;
    logic [IDX_W-1:0]   r_inv_rd;

    logic               r_out_vld;
    t_rsp               r_out;
    t_rsp               n_out;

    logic               accept;
    logic               out_free;
    logic               pos_ok;
    logic               sym_ok;
    logic [CW-1:0]      pos_w;
    logic [CW-1:0]      sym_w;
    logic [CW-1:0]      diff;
    logic [CW-1:0]      sum;
    logic [IDX_W-1:0]   base_idx;
    logic [IDX_W-1:0]   sym_idx;

    assign out_free = !r_out_vld || !i_stall;
    assign o_stall  = r_s1_vld && !out_free;
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_vld;
    assign o_rsp    = r_out;

    // base index = (position - rotation) mod SYMBOLS
    always_comb begin
        pos_w    = CW'(i_req.position);
        sym_w    = CW'(i_req.symbol);
        pos_ok   = pos_w < CW'(SYMBOLS);
        sym_ok   = sym_w < CW'(SYMBOLS);
        diff     = pos_w - CW'(r_rot);
        if (diff[CW-1]) begin
            diff = diff + CW'(SYMBOLS);
        end
        base_idx = diff[IDX_W-1:0];
        sym_idx  = sym_w[IDX_W-1:0];
    end

    always_comb begin
        n_rot  = r_rot;
        n_wrap = r_wrap;
        if (accept) begin
            unique case (i_req.kind)
                KIND_ROTATE: begin
                    n_rot  = (r_rot == IDX_W'(SYMBOLS - 1)) ? '0 : r_rot + IDX_W'(1);
                    n_wrap = (r_rot == IDX_W'(SYMBOLS - 1));
                end
                KIND_RESET: begin
                    n_rot = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot  <= '0;
            r_wrap <= 1'b0;
        end else begin
            r_rot  <= n_rot;
            r_wrap <= n_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_req.kind == KIND_LOAD && pos_ok) begin
                base_mem[base_idx] <= i_req.symbol;
                if (sym_ok) begin
                    inv_mem[sym_idx] <= base_idx;
                end
            end
            r_base_rd <= base_mem[base_idx];
            r_inv_rd  <= inv_mem[sym_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (out_free) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= i_req.kind;
            r_s1_ok   <= (i_req.kind == KIND_FORWARD) ? pos_ok : sym_ok;
            r_s1_rot  <= r_rot;
            r_s1_wrap <= n_wrap;
        end
    end

    // backward: (inverse entry + rotation) mod SYMBOLS
    always_comb begin
        sum = CW'(r_inv_rd) + CW'(r_s1_rot);
        if (sum >= CW'(SYMBOLS)) begin
            sum = sum - CW'(SYMBOLS);
        end
        n_out.wrapped = r_s1_wrap;
        unique case (r_s1_kind)
            KIND_FORWARD:  n_out.result = r_s1_ok ? r_base_rd : '0;
            KIND_BACKWARD: n_out.result = r_s1_ok ? sum[FIELD_W-1:0] : '0;
            default:       n_out.result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    a_rotate_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.kind == KIND_ROTATE && r_rot == IDX_W'(SYMBOLS - 1)
        |=> r_rot == '0 && r_wrap)
        else $error("rotate past last position did not wrap");

    a_reset_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.kind == KIND_RESET |=> r_rot == '0 && $stable(r_wrap))
        else $error("reset request did not clear count or changed flag");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_vld && r_out_vld && i_stall)
        else $error("input stalled while pipeline has room");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted request lost before read stage");

endmodule
